### rtl/core/gpio_port_with_edge_interrupts_top_defines.svh
// assertion macros for the gpio port bank with edge interrupts
// included by the modules of rtl/core that check their own logic
// empty bodies when SYNTHESIS is defined
`ifndef GPIO_PORT_WITH_EDGE_INTERRUPTS_TOP_DEFINES_SVH
`define GPIO_PORT_WITH_EDGE_INTERRUPTS_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GPE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gpe assertion failed");

// next-cycle implication
`define GPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gpe assertion failed");

`else

`define GPE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define GPE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/gpe_pkg.sv
// shared types, codes and constants of the gpio port bank
// no dependencies; imported by gpe_regs and the top level
`default_nettype none

package gpe_pkg;

   localparam int PORTS      = 6;
   localparam int PORT_SLOTS = 8;
   localparam int PIDX_W     = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam int MASK_W     = 6;
   localparam int DATA_W     = 8;
   localparam int NUM_W      = 3;
   localparam int OFF_W      = 3;
   localparam int PIN_W      = 3;

   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 32;

   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = MASK_W;

   localparam logic [CSR_IDX_W-1:0] CSR_INT_PORT_MASK    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_ENABLE_MASK = 1'd1;

   localparam logic [MASK_W-1:0] INT_PORT_MASK_RST    = 6'd3;
   localparam logic [MASK_W-1:0] PORT_ENABLE_MASK_RST = 6'd63;

   // register offsets, interrupt-capable port
   localparam logic [OFF_W-1:0] OFF_IN   = 3'd0;
   localparam logic [OFF_W-1:0] OFF_OUT  = 3'd1;
   localparam logic [OFF_W-1:0] OFF_DIR  = 3'd2;
   localparam logic [OFF_W-1:0] OFF_IFG  = 3'd3;
   localparam logic [OFF_W-1:0] OFF_IES  = 3'd4;
   localparam logic [OFF_W-1:0] OFF_IE   = 3'd5;
   localparam logic [OFF_W-1:0] OFF_ISEL = 3'd6;
   // plain port keeps SEL right after DIR
   localparam logic [OFF_W-1:0] OFF_PSEL = 3'd3;

   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_PIN   = 2'd2,
      REQ_ACK   = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      SEL_NONE,
      SEL_IN,
      SEL_OUT,
      SEL_DIR,
      SEL_IFG,
      SEL_IES,
      SEL_IE,
      SEL_SEL
   } reg_sel_type;

   typedef struct packed {
      req_code_type             req_type;
      logic [NUM_W-1:0]         port_id;
      logic [OFF_W-1:0]         reg_offset;
      logic [DATA_W-1:0]        data_value;
      logic [PIN_W-1:0]         pin_index;
   } gpe_item_type;

   typedef struct packed {
      logic [MASK_W-1:0]        irq_pending;
      logic [DATA_W-1:0]        new_out;
      logic [DATA_W-1:0]        old_out;
      logic                     out_changed;
      logic [DATA_W-1:0]        read_data;
   } gpe_result_type;

   typedef struct packed {
      logic [MASK_W-1:0]        int_port_mask;
      logic [MASK_W-1:0]        port_enable_mask;
   } gpe_cfg_type;

   // register map lookup for one port
   function automatic reg_sel_type reg_decode(input logic is_int,
                                              input logic [OFF_W-1:0] off);
      reg_sel_type sel;
      sel = SEL_NONE;
      if (is_int) begin
         case (off)
            OFF_IN:   sel = SEL_IN;
            OFF_OUT:  sel = SEL_OUT;
            OFF_DIR:  sel = SEL_DIR;
            OFF_IFG:  sel = SEL_IFG;
            OFF_IES:  sel = SEL_IES;
            OFF_IE:   sel = SEL_IE;
            OFF_ISEL: sel = SEL_SEL;
            default:  sel = SEL_NONE;
         endcase
      end else begin
         case (off)
            OFF_IN:   sel = SEL_IN;
            OFF_OUT:  sel = SEL_OUT;
            OFF_DIR:  sel = SEL_DIR;
            OFF_PSEL: sel = SEL_SEL;
            default:  sel = SEL_NONE;
         endcase
      end
      return sel;
   endfunction

endpackage

`default_nettype wire

### rtl/core/gpio_port_with_edge_interrupts_top.sv
// A bank of six byte-wide gpio ports with per-pin edge interrupts. Each req
// beat is a register read, a register write, a change of one input pin or
// an interrupt acknowledge, selected by req_tuser; each one gives exactly one
// rsp beat with the read data, any change of OUT and the per-port irq pending
// mask as it stands after the request. The block takes one beat per cycle
// while rsp_tready does not hold it back: a beat sits in the input register,
// passes the combinational register file update and lands in the result
// register, which raises rsp_tvalid. The result register alone sets the pace;
// while rsp_tready is low, one more beat is held in the input register. The
// two csr registers (port interrupt mask, port enable mask) are written
// through a plain write port and should only change while no beat is in flight.
// depends on gpe_pkg, gpe_regs and gpio_port_with_edge_interrupts_top_defines.svh
`default_nettype none
`include "gpio_port_with_edge_interrupts_top_defines.svh"

module gpio_port_with_edge_interrupts_top (
   input  wire                                 clock,
   input  wire                                 reset,
   // request stream
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // port_id[2:0], reg_offset[5:3], data_value[13:6], pin_index[16:14]
   input  wire  [gpe_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // req_type[1:0]
   input  wire  [gpe_pkg::REQ_TUSER_W-1:0]     req_tuser,
   // response stream
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // read_data[7:0], out_changed[8], old_out[16:9], new_out[24:17],
   // irq_pending[30:25]
   output logic [gpe_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // configuration writes
   input  wire                                 csr_we,
   input  wire  [gpe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [gpe_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import gpe_pkg::*;

   gpe_cfg_type    cfg_ff;
   logic           in_vld_ff;
   gpe_item_type   in_item_ff;
   logic           out_vld_ff;
   gpe_result_type out_res_ff;
   gpe_result_type res;
   gpe_item_type   req_item;
   logic           advance;
   logic           req_fire;

   // unpack the request beat
   assign req_item.req_type   = req_code_type'(req_tuser[1:0]);
   assign req_item.port_id    = req_tdata[2:0];
   assign req_item.reg_offset = req_tdata[5:3];
   assign req_item.data_value = req_tdata[13:6];
   assign req_item.pin_index  = req_tdata[16:14];

   // beat moves into the result register when that slot is free or drained
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.int_port_mask    <= INT_PORT_MASK_RST;
         cfg_ff.port_enable_mask <= PORT_ENABLE_MASK_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INT_PORT_MASK:    cfg_ff.int_port_mask    <= csr_wdata;
            CSR_PORT_ENABLE_MASK: cfg_ff.port_enable_mask <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
   end

   // register file and request logic
   gpe_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, out_res_ff};

   `GPE_ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !in_vld_ff, req_tready)
   `GPE_ASSERT_NEXT(a_advance_fills_rsp, clock, reset, advance, rsp_tvalid)
   `GPE_ASSERT_IMPLIES(a_no_overwrite, clock, reset, out_vld_ff && !rsp_tready, !advance)

endmodule

`default_nettype wire

### rtl/core/gpe_regs.sv
// per-port register file and single-pass request logic of the gpio bank
// depends on gpe_pkg and gpio_port_with_edge_interrupts_top_defines.svh
`default_nettype none
`include "gpio_port_with_edge_interrupts_top_defines.svh"

module gpe_regs (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     fire,
   input  gpe_pkg::gpe_item_type   item,
   input  gpe_pkg::gpe_cfg_type    cfg,
   output gpe_pkg::gpe_result_type result
);
   import gpe_pkg::*;

   logic [DATA_W-1:0] in_ff   [PORTS];
   logic [DATA_W-1:0] out_ff  [PORTS];
   logic [DATA_W-1:0] dir_ff  [PORTS];
   logic [DATA_W-1:0] sel_ff  [PORTS];
   logic [DATA_W-1:0] ifg_ff  [PORTS];
   logic [DATA_W-1:0] ies_ff  [PORTS];
   logic [DATA_W-1:0] ie_ff   [PORTS];

   logic [DATA_W-1:0] in_in   [PORTS];
   logic [DATA_W-1:0] out_in  [PORTS];
   logic [DATA_W-1:0] dir_in  [PORTS];
   logic [DATA_W-1:0] sel_in  [PORTS];
   logic [DATA_W-1:0] ifg_in  [PORTS];
   logic [DATA_W-1:0] ies_in  [PORTS];
   logic [DATA_W-1:0] ie_in   [PORTS];

   logic [PORT_SLOTS-1:0] int_ext;
   logic [PORT_SLOTS-1:0] en_ext;
   logic [PORT_SLOTS-1:0] pend_ext;
   logic [PIDX_W-1:0]     pidx;
   logic                  port_ok;
   logic                  is_int;
   logic                  is_en;
   reg_sel_type           rsel;
   logic [DATA_W-1:0]     cur;
   logic [DATA_W-1:0]     bit_m;
   logic                  level;
   logic                  was;
   logic [DATA_W-1:0]     act;
   logic [DATA_W-1:0]     low;

   assign int_ext = {{(PORT_SLOTS-MASK_W){1'b0}}, cfg.int_port_mask};
   assign en_ext  = {{(PORT_SLOTS-MASK_W){1'b0}}, cfg.port_enable_mask};
   assign port_ok = ({1'b0, item.port_id} < (NUM_W+1)'(PORTS));
   assign pidx    = item.port_id[PIDX_W-1:0];
   assign is_int  = port_ok && int_ext[item.port_id];
   assign is_en   = port_ok && en_ext[item.port_id];
   assign rsel    = reg_decode(is_int, item.reg_offset);
   assign bit_m   = DATA_W'(1) << item.pin_index;
   assign level   = item.data_value[0];

   // current value of the addressed register
   always_comb begin
      case (rsel)
         SEL_IN:  cur = in_ff[pidx];
         SEL_OUT: cur = out_ff[pidx];
         SEL_DIR: cur = dir_ff[pidx];
         SEL_SEL: cur = sel_ff[pidx];
         SEL_IFG: cur = ifg_ff[pidx];
         SEL_IES: cur = ies_ff[pidx];
         SEL_IE:  cur = ie_ff[pidx];
         default: cur = '0;
      endcase
   end

   assign was = |(in_ff[pidx] & bit_m);
   assign act = ifg_ff[pidx] & ie_ff[pidx];
   assign low = act & (~act + DATA_W'(1));

   always_comb begin
      in_in  = in_ff;
      out_in = out_ff;
      dir_in = dir_ff;
      sel_in = sel_ff;
      ifg_in = ifg_ff;
      ies_in = ies_ff;
      ie_in  = ie_ff;
      result = '0;
      if (port_ok) begin
         case (item.req_type)
            REQ_READ: begin
               if (is_en) begin
                  result.read_data = cur;
               end
            end
            REQ_WRITE: begin
               if (is_en) begin
                  case (rsel)
                     SEL_IN:  in_in[pidx]  = item.data_value;
                     SEL_OUT: out_in[pidx] = item.data_value;
                     SEL_DIR: dir_in[pidx] = item.data_value;
                     SEL_SEL: sel_in[pidx] = item.data_value;
                     SEL_IFG: ifg_in[pidx] = item.data_value;
                     SEL_IES: ies_in[pidx] = item.data_value;
                     SEL_IE:  ie_in[pidx]  = item.data_value;
                     default: ;
                  endcase
                  if (rsel == SEL_OUT && cur != item.data_value) begin
                     result.out_changed = 1'b1;
                     result.old_out     = cur;
                     result.new_out     = item.data_value;
                  end
               end
            end
            REQ_PIN: begin
               if (level) begin
                  in_in[pidx] = in_ff[pidx] | bit_m;
               end else begin
                  in_in[pidx] = in_ff[pidx] & ~bit_m;
               end
               // edge matches the polarity chosen in IES
               if (is_int && was != level && (|(ies_ff[pidx] & bit_m)) != level) begin
                  ifg_in[pidx] = ifg_ff[pidx] | bit_m;
               end
            end
            REQ_ACK: begin
               if (is_int) begin
                  ifg_in[pidx] = ifg_ff[pidx] & ~low;
               end
            end
            default: ;
         endcase
      end
      // pending mask after the update
      pend_ext = '0;
      for (int q = 0; q < PORTS; q++) begin
         pend_ext[q] = int_ext[q] && (|(ifg_in[q] & ie_in[q]));
      end
      result.irq_pending = pend_ext[MASK_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < PORTS; q++) begin
            in_ff[q]  <= '0;
            out_ff[q] <= '0;
            dir_ff[q] <= '0;
            sel_ff[q] <= '0;
            ifg_ff[q] <= '0;
            ies_ff[q] <= '0;
            ie_ff[q]  <= '0;
         end
      end else if (fire) begin
         in_ff  <= in_in;
         out_ff <= out_in;
         dir_ff <= dir_in;
         sel_ff <= sel_in;
         ifg_ff <= ifg_in;
         ies_ff <= ies_in;
         ie_ff  <= ie_in;
      end
   end

   `GPE_ASSERT_IMPLIES(a_chg_differs, clock, reset, result.out_changed,
      result.old_out != result.new_out)
   `GPE_ASSERT_IMPLIES(a_irq_only_int_ports, clock, reset, 1'b1,
      (result.irq_pending & ~cfg.int_port_mask) == '0)
   `GPE_ASSERT_IMPLIES(a_rd_only_on_read, clock, reset, item.req_type != REQ_READ,
      result.read_data == '0)

endmodule

`default_nettype wire
